FILE: design/reverse_and_add_palindrome_assert.svh
// Assertion macros for the reverse-and-add block.
// RAP_ASSERT_IMP checks a same-cycle implication, RAP_ASSERT_NXT a next-cycle one.
`ifndef REVERSE_AND_ADD_PALINDROME_ASSERT_SVH
`define REVERSE_AND_ADD_PALINDROME_ASSERT_SVH
`ifndef SYNTHESIS
`define RAP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define RAP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RAP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define RAP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: design/rap_pkg.sv
package rap_pkg;

   // Field widths of the request and response beats
   localparam int unsigned VALUE_W   = 32;
   localparam int unsigned INDEX_W   = 4;
   localparam int unsigned COUNT_W   = 4;
   localparam int unsigned DIGIT_W   = 4;
   localparam int unsigned REV_W     = 34;
   localparam int unsigned STEP_W    = 8;
   localparam logic [STEP_W-1:0] STEP_MAX = '1;

   // Digit position counter, enough for 20 decimal digits
   localparam int unsigned POS_W     = 5;

   // Default datapath width of the iteration
   localparam int unsigned DEF_WIDTH = 32;

   // Width converted by the reverse unit: the value itself or the iterate
   function automatic int unsigned conv_width(input int unsigned w);
      return (w > VALUE_W) ? w : VALUE_W;
   endfunction

   // Decimal digits of 2**w - 1 (1233/4096 approximates log10(2))
   function automatic int unsigned max_dec_digits(input int unsigned w);
      return ((w * 1233) >> 12) + 1;
   endfunction

   // Status of the reverse unit towards the sequencer
   typedef struct packed {
      logic               busy;
      logic               done;
      logic               dig_strobe;
      logic [DIGIT_W-1:0] digit;
      logic [POS_W-1:0]   pos;
   } rap_unit_stat_type;

endpackage

FILE: design/rap_rev_unit.sv
`include "reverse_and_add_palindrome_assert.svh"

// Shared digit-reverse unit: double-dabble conversion one bit a cycle,
// then Horner accumulation of the digits from the units upwards.
module rap_rev_unit #(
   parameter int unsigned WIDTH = rap_pkg::DEF_WIDTH,
   localparam int unsigned CW   = rap_pkg::conv_width(WIDTH),
   localparam int unsigned RW   = CW + 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [CW-1:0]              operand,
   output rap_pkg::rap_unit_stat_type stat,
   output logic [RW-1:0]              rev
);
   import rap_pkg::*;

   localparam int unsigned ND    = max_dec_digits(CW);
   localparam int unsigned BW    = 4 * ND;
   localparam int unsigned CNT_W = $clog2(CW + 1);
   localparam logic [3:0]  ADJ_MIN = 4'd5;
   localparam logic [3:0]  ADJ_ADD = 4'd3;
   localparam logic [3:0]  DIGIT_MAX = 4'd9;

   typedef enum logic [2:0] {
      U_IDLE = 3'b001,
      U_CONV = 3'b010,
      U_ACC  = 3'b100
   } unit_state_type;

   unit_state_type     state_ff, state_in;
   logic [CW-1:0]      bin_ff, bin_in;
   logic [BW-1:0]      bcd_ff, bcd_in;
   logic [BW-1:0]      bcd_adj;
   logic [BW-1:0]      rem_next;
   logic [RW-1:0]      rev_ff, rev_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [DIGIT_W-1:0] digit;

   // add-3 correction on every BCD digit before the shift
   always_comb begin
      for (int i = 0; i < ND; i++) begin
         bcd_adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= ADJ_MIN) ?
                             bcd_ff[4*i +: 4] + ADJ_ADD : bcd_ff[4*i +: 4];
      end
   end

   assign digit    = bcd_ff[DIGIT_W-1:0];
   assign rem_next = bcd_ff >> 4;

   // sequencer of the unit
   always_comb begin
      state_in = state_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      rev_in   = rev_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      case (state_ff)
         U_IDLE: begin
            if (start) begin
               bin_in   = operand;
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = U_CONV;
            end
         end
         U_CONV: begin
            {bcd_in, bin_in} = {bcd_adj[BW-2:0], bin_ff, 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CW - 1)) begin
               cnt_in   = '0;
               rev_in   = '0;
               state_in = U_ACC;
            end
         end
         U_ACC: begin
            // rev * 10 + digit
            rev_in = (rev_ff << 3) + (rev_ff << 1) + RW'(digit);
            bcd_in = rem_next;
            cnt_in = cnt_ff + 1'b1;
            if (rem_next == '0) begin
               done_in  = 1'b1;
               state_in = U_IDLE;
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      rev_ff <= rev_in;
      cnt_ff <= cnt_in;
   end

   // pos is the digit under the strobe, and the digit count once done
   assign stat.busy       = (state_ff != U_IDLE);
   assign stat.done       = done_ff;
   assign stat.dig_strobe = (state_ff == U_ACC);
   assign stat.digit      = digit;
   assign stat.pos        = cnt_ff[POS_W-1:0];
   assign rev             = rev_ff;

   `RAP_ASSERT_IMP(a_start_idle, clock, reset, start, state_ff == U_IDLE, "start while busy")
   `RAP_ASSERT_IMP(a_done_after_acc, clock, reset, done_ff, $past(state_ff == U_ACC),
                   "done without accumulation")
   `RAP_ASSERT_IMP(a_acc_digit_dec, clock, reset, state_ff == U_ACC, digit <= DIGIT_MAX,
                   "non-decimal digit in accumulation")

endmodule

FILE: design/reverse_and_add_palindrome.sv
// Channel | Dir | Handshake           | Payload
// req     | in  | req_valid/req_ready | value, digit index
// rsp     | out | rsp_valid/rsp_ready | count, digit, reverse, flags, steps, final
//
// One item at a time. Each round runs the shared reverse unit: double-dabble
// conversion of CW bits (CW = max(WIDTH, 32)), accumulation of one decimal digit
// at a time, then the done strobe and the evaluation.
// The beat waits in an output register, so the next item may run meanwhile.
// Reset (synchronous) returns to idle; input stalls while an item runs or waits.
module reverse_and_add_palindrome #(
   parameter int unsigned WIDTH = rap_pkg::DEF_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rap_pkg::VALUE_W-1:0]  req_value,
   input  logic [rap_pkg::INDEX_W-1:0]  req_digit_index,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rap_pkg::COUNT_W-1:0]  rsp_digit_count,
   output logic [rap_pkg::DIGIT_W-1:0]  rsp_selected_digit,
   output logic                         rsp_digit_valid,
   output logic [rap_pkg::REV_W-1:0]    rsp_reversed_value,
   output logic                         rsp_palindrome_flag,
   output logic                         rsp_verdict,
   output logic [rap_pkg::STEP_W-1:0]   rsp_step_count,
   output logic [rap_pkg::VALUE_W-1:0]  rsp_final_value
);
   import rap_pkg::*;

   localparam int unsigned CW = conv_width(WIDTH);
   localparam int unsigned RW = CW + 4;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RUN  = 4'b0010,
      S_EVAL = 4'b0100,
      S_DONE = 4'b1000
   } seq_state_type;

   seq_state_type      state_ff, state_in;
   logic [VALUE_W-1:0] val_ff, val_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;
   logic [WIDTH-1:0]   v_ff, v_in;
   logic               first_ff, first_in;
   logic [STEP_W-1:0]  steps_ff, steps_in;
   logic [DIGIT_W-1:0] sel_ff, sel_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               dv_ff, dv_in;
   logic [REV_W-1:0]   rev_out_ff, rev_out_in;
   logic               pal_ff, pal_in;
   logic               verdict_ff, verdict_in;
   logic [VALUE_W-1:0] final_ff, final_in;

   logic               out_valid_ff, out_valid_in;
   logic [COUNT_W-1:0] out_count_ff;
   logic [DIGIT_W-1:0] out_sel_ff;
   logic               out_dv_ff;
   logic [REV_W-1:0]   out_rev_ff;
   logic               out_pal_ff;
   logic               out_verdict_ff;
   logic [STEP_W-1:0]  out_steps_ff;
   logic [VALUE_W-1:0] out_final_ff;
   logic               load_out;

   rap_unit_stat_type  stat;
   logic [RW-1:0]      rev;
   logic               start;
   logic [CW-1:0]      operand;
   logic [RW:0]        sum;
   logic               over;
   logic               too_wide;
   logic               accept;

   rap_rev_unit #(
      .WIDTH (WIDTH)
   ) u_rev (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .operand (operand),
      .stat    (stat),
      .rev     (rev)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = out_valid_ff;
   assign accept    = req_valid && req_ready;

   // finished item moves out once the output register is free or drains
   assign load_out     = (state_ff == S_DONE) && (!out_valid_ff || rsp_ready);
   assign out_valid_in = load_out || (out_valid_ff && !rsp_ready);

   // next sum and its overflow past WIDTH bits
   assign sum      = (RW + 1)'(rev) + (RW + 1)'(v_ff);
   assign over     = |(sum >> WIDTH);
   assign too_wide = |(CW'(val_ff) >> WIDTH);

   // round sequencer
   always_comb begin
      state_in   = state_ff;
      val_in     = val_ff;
      idx_in     = idx_ff;
      v_in       = v_ff;
      first_in   = first_ff;
      steps_in   = steps_ff;
      sel_in     = sel_ff;
      count_in   = count_ff;
      dv_in      = dv_ff;
      rev_out_in = rev_out_ff;
      pal_in     = pal_ff;
      verdict_in = verdict_ff;
      final_in   = final_ff;
      start      = 1'b0;
      operand    = CW'(req_value);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in   = req_value;
               idx_in   = req_digit_index;
               v_in     = WIDTH'(req_value);
               first_in = 1'b1;
               steps_in = '0;
               sel_in   = '0;
               start    = 1'b1;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            // pick the digit of the start value as it streams past
            if (stat.dig_strobe && first_ff && (stat.pos == POS_W'(idx_ff))) begin
               sel_in = stat.digit;
            end
            if (stat.done) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            first_in = 1'b0;
            if (first_ff) begin
               count_in   = stat.pos[COUNT_W-1:0];
               dv_in      = ({1'b0, idx_ff} < stat.pos);
               rev_out_in = rev[REV_W-1:0];
               pal_in     = (rev == RW'(val_ff));
            end
            if (first_ff && too_wide) begin
               verdict_in = 1'b1;
               final_in   = val_ff;
               state_in   = S_DONE;
            end else if (rev == RW'(v_ff)) begin
               verdict_in = 1'b0;
               final_in   = VALUE_W'(v_ff);
               state_in   = S_DONE;
            end else if (over) begin
               verdict_in = 1'b1;
               final_in   = VALUE_W'(v_ff);
               state_in   = S_DONE;
            end else begin
               v_in     = sum[WIDTH-1:0];
               steps_in = (steps_ff == STEP_MAX) ? steps_ff : steps_ff + 1'b1;
               start    = 1'b1;
               operand  = CW'(sum[WIDTH-1:0]);
               state_in = S_RUN;
            end
         end
         S_DONE: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         first_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         out_valid_ff <= out_valid_in;
      end
      val_ff     <= val_in;
      idx_ff     <= idx_in;
      v_ff       <= v_in;
      steps_ff   <= steps_in;
      sel_ff     <= sel_in;
      count_ff   <= count_in;
      dv_ff      <= dv_in;
      rev_out_ff <= rev_out_in;
      pal_ff     <= pal_in;
      verdict_ff <= verdict_in;
      final_ff   <= final_in;
   end

   // output register, held until the beat is taken
   always_ff @(posedge clock) begin
      if (load_out) begin
         out_count_ff   <= count_ff;
         out_sel_ff     <= sel_ff;
         out_dv_ff      <= dv_ff;
         out_rev_ff     <= rev_out_ff;
         out_pal_ff     <= pal_ff;
         out_verdict_ff <= verdict_ff;
         out_steps_ff   <= steps_ff;
         out_final_ff   <= final_ff;
      end
   end

   assign rsp_digit_count     = out_count_ff;
   assign rsp_selected_digit  = out_sel_ff;
   assign rsp_digit_valid     = out_dv_ff;
   assign rsp_reversed_value  = out_rev_ff;
   assign rsp_palindrome_flag = out_pal_ff;
   assign rsp_verdict         = out_verdict_ff;
   assign rsp_step_count      = out_steps_ff;
   assign rsp_final_value     = out_final_ff;

   `RAP_ASSERT_NXT(a_accept_starts_unit, clock, reset, accept, stat.busy,
                   "reverse unit not started on accept")
   `RAP_ASSERT_IMP(a_invalid_digit_zero, clock, reset, rsp_valid && !rsp_digit_valid,
                   rsp_selected_digit == '0, "digit set beyond the digit count")
   `RAP_ASSERT_IMP(a_zero_steps_pal, clock, reset,
                   rsp_valid && !rsp_verdict && (rsp_step_count == '0),
                   rsp_palindrome_flag, "palindrome reached at once but flag clear")

endmodule

FILE: bench/tb_reverse_and_add_palindrome.sv
`timescale 1ns / 1ps

module tb_reverse_and_add_palindrome;
   import rap_pkg::*;

   localparam int unsigned WIDTH = DEF_WIDTH;
   localparam longint unsigned U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam longint unsigned RADIX = 10;

   // one expected response beat
   typedef struct packed {
      logic [COUNT_W-1:0] digit_count;
      logic [DIGIT_W-1:0] selected_digit;
      logic               digit_valid;
      logic [REV_W-1:0]   reversed_value;
      logic               palindrome_flag;
      logic               verdict;
      logic [STEP_W-1:0]  step_count;
      logic [VALUE_W-1:0] final_value;
   } outcome_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [VALUE_W-1:0]  req_value;
   logic [INDEX_W-1:0]  req_digit_index;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [COUNT_W-1:0]  rsp_digit_count;
   logic [DIGIT_W-1:0]  rsp_selected_digit;
   logic                rsp_digit_valid;
   logic [REV_W-1:0]    rsp_reversed_value;
   logic                rsp_palindrome_flag;
   logic                rsp_verdict;
   logic [STEP_W-1:0]   rsp_step_count;
   logic [VALUE_W-1:0]  rsp_final_value;

   outcome_type outcome_q [$];
   int          error_count = 0;
   bit          sender_gaps_on = 1'b1;
   bit          rsp_stalls_on = 1'b1;
   int          rsp_hold_cycles = 0;
   int          rsp_stall_left = 0;

   reverse_and_add_palindrome #(.WIDTH(WIDTH)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_value           (req_value),
      .req_digit_index     (req_digit_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_digit_count     (rsp_digit_count),
      .rsp_selected_digit  (rsp_selected_digit),
      .rsp_digit_valid     (rsp_digit_valid),
      .rsp_reversed_value  (rsp_reversed_value),
      .rsp_palindrome_flag (rsp_palindrome_flag),
      .rsp_verdict         (rsp_verdict),
      .rsp_step_count      (rsp_step_count),
      .rsp_final_value     (rsp_final_value)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decimal reverse; flags a reverse that would not fit in 64 bits
   function automatic longint unsigned reverse_digits(input longint unsigned v,
                                                      output bit too_wide);
      longint unsigned r;
      longint unsigned d;
      r = 0;
      too_wide = 1'b0;
      do begin
         d = v % RADIX;
         if (r > (U64_MAX - d) / RADIX) begin
            too_wide = 1'b1;
            return 0;
         end
         r = r * RADIX + d;
         v = v / RADIX;
      end while (v != 0);
      return r;
   endfunction

   // full expected beat for one request
   function automatic outcome_type examine_value(input logic [VALUE_W-1:0] value,
                                                 input logic [INDEX_W-1:0] idx);
      outcome_type     o;
      longint unsigned lim, t, rev, v, r, sel;
      int unsigned     count, k, steps;
      bit              ovf, finished, verdict;
      lim = ((64'd1 << (WIDTH - 1)) * 2) - 1;
      count = 0;
      t = value;
      do begin
         count++;
         t = t / RADIX;
      end while (t != 0);
      sel = 0;
      if (idx < count) begin
         t = value;
         for (k = 0; k < idx; k++)
            t = t / RADIX;
         sel = t % RADIX;
      end
      rev = reverse_digits(value, ovf);
      // reverse-and-add rounds until palindrome or sum overflow
      v = value;
      steps = 0;
      verdict = 1'b0;
      if (v > lim) begin
         verdict = 1'b1;
      end else begin
         finished = 1'b0;
         while (!finished) begin
            r = reverse_digits(v, ovf);
            if (!ovf && r == v) begin
               verdict = 1'b0;
               finished = 1'b1;
            end else if (ovf || r > lim - v) begin
               verdict = 1'b1;
               finished = 1'b1;
            end else begin
               v = v + r;
               if (steps < 255)
                  steps++;
            end
         end
      end
      o.digit_count     = count[COUNT_W-1:0];
      o.selected_digit  = sel[DIGIT_W-1:0];
      o.digit_valid     = (idx < count);
      o.reversed_value  = rev[REV_W-1:0];
      o.palindrome_flag = (rev == value);
      o.verdict         = verdict;
      o.step_count      = steps[STEP_W-1:0];
      o.final_value     = v[VALUE_W-1:0];
      return o;
   endfunction

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(16, 80);
   endfunction

   // raw words, values of a chosen digit length, some with trailing zeros
   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned     sel, nd;
      longint unsigned lo, hi, p, t;
      sel = $urandom_range(0, 9);
      if (sel < 4) return $urandom;
      nd = $urandom_range(1, 10);
      lo = 1;
      repeat (nd - 1) lo = lo * RADIX;
      hi = lo * RADIX - 1;
      if (nd == 1) lo = 0;
      if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
      p = $urandom_range(hi[31:0], lo[31:0]);
      if (sel == 9) begin
         t = 1;
         repeat ($urandom_range(1, 4)) t = t * RADIX;
         p = (p / t) * t;
      end
      return p[VALUE_W-1:0];
   endfunction

   // half in range of typical digit counts, half over the whole field
   function automatic logic [INDEX_W-1:0] pick_index();
      if ($urandom_range(0, 1) == 0) return INDEX_W'($urandom_range(0, 9));
      return INDEX_W'($urandom_range(0, 15));
   endfunction

   // random decimal palindrome that fits the value field
   function automatic logic [VALUE_W-1:0] make_palindrome();
      int unsigned     dig [0:9];
      int unsigned     nd, k;
      longint unsigned p;
      do begin
         nd = $urandom_range(1, 10);
         for (k = 0; k < (nd + 1) / 2; k++)
            dig[k] = (k == 0 && nd > 1) ? $urandom_range(1, 9) : $urandom_range(0, 9);
         for (k = (nd + 1) / 2; k < nd; k++)
            dig[k] = dig[nd - 1 - k];
         p = 0;
         for (k = 0; k < nd; k++)
            p = p * RADIX + dig[k];
      end while (p > 64'hFFFF_FFFF);
      return p[VALUE_W-1:0];
   endfunction

   task automatic report_mismatch(input string what, input longint unsigned got,
                                  input longint unsigned want);
      error_count++;
      if (error_count <= 50)
         $display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
   endtask

   // send one request beat; entered and left at a falling edge
   task automatic send_item(input logic [VALUE_W-1:0] value,
                            input logic [INDEX_W-1:0] idx);
      int gap;
      gap = sender_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_value       <= value;
      req_digit_index <= idx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      outcome_q.push_back(examine_value(value, idx));
      @(negedge clock);
   endtask

   // receiver: long hold-off on request, else random stalls
   always @(negedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles--;
      end else if (rsp_stall_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_stall_left--;
      end else if (rsp_stalls_on && $urandom_range(0, 3) == 0) begin
         rsp_stall_left = pick_gap();
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcome_q.size() == 0) begin
            report_mismatch("unexpected beat, final_value", rsp_final_value, 0);
         end else begin
            want = outcome_q.pop_front();
            if (rsp_digit_count !== want.digit_count)
               report_mismatch("digit_count", rsp_digit_count, want.digit_count);
            if (rsp_selected_digit !== want.selected_digit)
               report_mismatch("selected_digit", rsp_selected_digit, want.selected_digit);
            if (rsp_digit_valid !== want.digit_valid)
               report_mismatch("digit_valid", rsp_digit_valid, want.digit_valid);
            if (rsp_reversed_value !== want.reversed_value)
               report_mismatch("reversed_value", rsp_reversed_value, want.reversed_value);
            if (rsp_palindrome_flag !== want.palindrome_flag)
               report_mismatch("palindrome_flag", rsp_palindrome_flag,
                               want.palindrome_flag);
            if (rsp_verdict !== want.verdict)
               report_mismatch("verdict", rsp_verdict, want.verdict);
            if (rsp_step_count !== want.step_count)
               report_mismatch("step_count", rsp_step_count, want.step_count);
            if (rsp_final_value !== want.final_value)
               report_mismatch("final_value", rsp_final_value, want.final_value);
         end
      end
   end

   // zero, single digits, trailing zeros, index past the digits, palindromes,
   // the largest value, reverses wider than the value field, long iterations
   task automatic test_digit_extremes();
      logic [VALUE_W-1:0] vals [0:23];
      logic [INDEX_W-1:0] idxs [0:23];
      int                 k;
      vals = '{32'd0, 32'd0, 32'd9, 32'd10, 32'd120, 32'd120, 32'd12321,
               32'd4294967295, 32'd4294967295, 32'd4294967295, 32'd1000000000,
               32'd1000000000, 32'd1999999999, 32'd196, 32'd89, 32'd10101, 32'd11,
               32'd4294967294, 32'd2147483648, 32'd1234567890, 32'd1, 32'd99,
               32'd3000000003, 32'd5};
      idxs = '{4'd0, 4'd15, 4'd0, 4'd1, 4'd0, 4'd3, 4'd2, 4'd9, 4'd10, 4'd15, 4'd9,
               4'd0, 4'd5, 4'd1, 4'd0, 4'd4, 4'd1, 4'd3, 4'd7, 4'd8, 4'd15, 4'd0,
               4'd9, 4'd1};
      for (k = 0; k < 24; k++)
         send_item(vals[k], idxs[k]);
   endtask

   task automatic test_random_values();
      repeat (600) send_item(pick_value(), pick_index());
   endtask

   task automatic test_palindromic_starts();
      repeat (150) send_item(make_palindrome(), pick_index());
   endtask

   // no idling on either side
   task automatic test_back_to_back();
      sender_gaps_on = 1'b0;
      rsp_stalls_on  = 1'b0;
      repeat (130) send_item(pick_value(), pick_index());
      sender_gaps_on = 1'b1;
      rsp_stalls_on  = 1'b1;
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_input_stall();
      sender_gaps_on  = 1'b0;
      rsp_hold_cycles = 3000;
      repeat (10) send_item(pick_value(), pick_index());
      sender_gaps_on  = 1'b1;
      repeat (30) send_item(pick_value(), pick_index());
   endtask

   // main sequence
   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_value       = '0;
      req_digit_index = '0;
      rsp_ready       = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_digit_extremes();
      test_random_values();
      test_palindromic_starts();
      test_back_to_back();
      test_input_stall();

      req_valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0)
         $display("tb_reverse_and_add_palindrome: PASS");
      else
         $display("tb_reverse_and_add_palindrome: FAIL");
      $finish;
   end

   // run limit
   initial begin
      #400_000_000;
      $display("tb_reverse_and_add_palindrome: FAIL");
      $finish;
   end

endmodule
